@@ rtl/bli_pkg.sv @@
package bli_pkg;

    localparam int PERMILLE_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int LEVEL_W    = 8;

    localparam logic [PERMILLE_W-1:0] PERMILLE_SCALE = 10'd1000;

    localparam logic [PERMILLE_W-1:0] RST_CRITICAL = 10'd71;
    localparam logic [PERMILLE_W-1:0] RST_LOW      = 10'd137;
    localparam logic [PERMILLE_W-1:0] RST_FULL     = 10'd937;

    localparam logic [CFG_IDX_W-1:0] REG_AUTO_CONTROL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL         = 3'd3;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_MANUAL = 1'b1;

    localparam logic [2:0] CS_CHARGE    = 3'd0;
    localparam logic [2:0] CS_NEAR_FULL = 3'd1;
    localparam logic [2:0] CS_DISCHARGE = 3'd2;
    localparam logic [2:0] CS_ERROR     = 3'd3;
    localparam logic [2:0] CS_IDLE      = 3'd4;

    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_BAD_TARGET = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                  auto_control;
        logic [PERMILLE_W-1:0] critical_permille;
        logic [PERMILLE_W-1:0] low_permille;
        logic [PERMILLE_W-1:0] full_permille;
    } t_cfg;

    // Item fields the LED policy looks at, with the levels reduced to flags.
    typedef struct packed {
        logic       cmd;
        logic [2:0] batt_state;
        logic       force_idle;
        logic       chipset_off;
        logic       target_is_battery;
        logic       red_req;
        logic       green_req;
    } t_ctl;

    typedef struct packed {
        logic red;
        logic green;
        logic status;
    } t_res;

endpackage

@@ rtl/bli_if.sv @@
interface bli_in_if #(
    parameter int CAP_WIDTH = 16
);
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [2:0]           batt_state;
    logic                 force_idle;
    logic                 chipset_off;
    logic [CAP_WIDTH-1:0] remain_cap;
    logic [CAP_WIDTH-1:0] full_capacity;
    logic                 target_is_battery;
    logic [7:0]           red_level;
    logic [7:0]           green_level;

    modport source (
        output valid, cmd, batt_state, force_idle, chipset_off, remain_cap,
               full_capacity, target_is_battery, red_level, green_level,
        input  ready
    );
    modport sink (
        input  valid, cmd, batt_state, force_idle, chipset_off, remain_cap,
               full_capacity, target_is_battery, red_level, green_level,
        output ready
    );
endinterface

interface bli_out_if;
    logic valid;
    logic ready;
    logic red_on;
    logic green_on;
    logic status;

    modport source (output valid, red_on, green_on, status, input ready);
    modport sink (input valid, red_on, green_on, status, output ready);
endinterface

interface bli_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/bli_div.sv @@
module bli_div #(
    parameter int CAP_WIDTH = 16,
    parameter int QW        = CAP_WIDTH + 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [QW-1:0]        i_dividend,
    input  logic [CAP_WIDTH-1:0] i_divisor,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [QW-1:0]        o_quotient
);
    localparam int CNT_W = $clog2(QW + 1);

    logic [CNT_W-1:0]     r_cnt,  n_cnt;
    logic                 r_done, n_done;
    logic [QW-1:0]        r_q,    n_q;
    logic [CAP_WIDTH-1:0] r_rem,  n_rem;
    logic [CAP_WIDTH-1:0] r_dvs,  n_dvs;
    logic [CAP_WIDTH+1:0] w_trial;

    // One quotient bit a cycle: shift the dividend MSB into the remainder.
    assign w_trial = {1'b0, r_rem, r_q[QW-1]} - {2'b00, r_dvs};

    always_comb begin
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_done = 1'b0;
        if (i_start) begin
            n_cnt = CNT_W'(QW);
            n_q   = i_dividend;
            n_rem = '0;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
            if (w_trial[CAP_WIDTH+1]) begin
                n_rem = {r_rem[CAP_WIDTH-2:0], r_q[QW-1]};
                n_q   = {r_q[QW-2:0], 1'b0};
            end else begin
                n_rem = w_trial[CAP_WIDTH-1:0];
                n_q   = {r_q[QW-2:0], 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy     = (r_cnt != '0);
    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

@@ rtl/bli_policy.sv @@
module bli_policy #(
    parameter int PM_WIDTH = 26
) (
    input  bli_pkg::t_ctl        i_ctl,
    input  bli_pkg::t_cfg        i_cfg,
    input  logic [1:0]           i_blink,
    input  logic [PM_WIDTH-1:0]  i_pm,
    input  logic                 i_red,
    input  logic                 i_green,
    output bli_pkg::t_res        o_res
);
    import bli_pkg::*;

    logic w_below_full;
    logic w_at_crit;
    logic w_at_low;

    assign w_below_full = i_pm <  PM_WIDTH'(i_cfg.full_permille);
    assign w_at_crit    = i_pm <= PM_WIDTH'(i_cfg.critical_permille);
    assign w_at_low     = i_pm <= PM_WIDTH'(i_cfg.low_permille);

    always_comb begin
        o_res.red    = i_red;
        o_res.green  = i_green;
        o_res.status = STATUS_OK;
        if (i_ctl.cmd == CMD_TICK) begin
            if (i_cfg.auto_control) begin
                case (i_ctl.batt_state)
                    CS_CHARGE: begin
                        o_res.red   = !w_below_full;
                        o_res.green = w_below_full;
                    end
                    CS_NEAR_FULL: begin
                        o_res.red   = 1'b1;
                        o_res.green = 1'b0;
                    end
                    CS_DISCHARGE: begin
                        o_res.red = 1'b0;
                        if (!i_ctl.chipset_off && w_at_crit) begin
                            o_res.green = !i_blink[0];
                        end else if (!i_ctl.chipset_off && w_at_low) begin
                            o_res.green = (i_blink == 2'b00);
                        end else begin
                            o_res.green = 1'b0;
                        end
                    end
                    CS_ERROR: begin
                        o_res.red   = 1'b0;
                        o_res.green = !i_blink[0];
                    end
                    CS_IDLE: begin
                        if (i_ctl.force_idle) begin
                            o_res.red   = !i_blink[1];
                            o_res.green = i_blink[1];
                        end else begin
                            o_res.red   = 1'b1;
                            o_res.green = 1'b0;
                        end
                    end
                    default: begin
                        // hold the LEDs
                    end
                endcase
            end
        end else if (i_ctl.target_is_battery) begin
            o_res.red   = i_ctl.red_req;
            o_res.green = !i_ctl.red_req && i_ctl.green_req;
        end else begin
            o_res.status = STATUS_BAD_TARGET;
        end
    end

endmodule

@@ rtl/battery_led_indicator_policy.sv @@
// Channel  Dir  Modport  Transaction
// -------  ---  -------  -------------------------------------------------
// i_in     in   sink     one tick or manual-set item, CAP_WIDTH capacities
// o_out    out  source   red_on, green_on, status; one per input item
// i_cfg    in   sink     register index and 10-bit write data, always ready
//
// A tick with auto control on, a known full capacity and a charge or
// discharge state runs the bit-serial permille divider, one quotient bit
// per cycle. Every other item goes straight to the done state. Synchronous
// active-low reset clears the blink counter, both LEDs and loads the
// register defaults. A stalled output holds the finished result; the next
// item is still taken and computed, then holds in the done state until the
// output register drains.
module battery_led_indicator_policy #(
    parameter int CAP_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bli_in_if.sink     i_in,
    bli_out_if.source  o_out,
    bli_cfg_if.sink    i_cfg
);
    import bli_pkg::*;

    // Quotient of 1000*remaining/full can reach 1000 * (2^CAP_WIDTH - 1).
    localparam int QW = CAP_WIDTH + PERMILLE_W;

    t_state  r_state, n_state;
    t_cfg    r_cfg;
    t_ctl    r_ctl;
    logic    r_use_div;
    logic [1:0] r_blink;
    logic    r_red;
    logic    r_green;
    logic    r_out_valid;
    t_res    r_out;

    logic          w_in_acc;
    logic          w_need_div;
    logic          w_start;
    logic          w_load;
    logic [1:0]    w_blink;
    logic [QW-1:0] w_dividend;
    logic [QW-1:0] w_quot;
    logic [QW-1:0] w_pm;
    logic          w_div_busy;
    logic          w_div_done;
    t_ctl          w_ctl;
    t_res          w_res;

    // Take an item only with no earlier one in flight.
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;

    // Divide only where the permille actually matters; full == 0 means 0.
    assign w_need_div = (i_in.cmd == CMD_TICK) && r_cfg.auto_control
                        && (i_in.full_capacity != '0)
                        && ((i_in.batt_state == CS_CHARGE)
                            || (i_in.batt_state == CS_DISCHARGE));
    assign w_start    = w_in_acc && w_need_div;
    assign w_dividend = QW'(i_in.remain_cap) * QW'(PERMILLE_SCALE);

    assign w_ctl.cmd               = i_in.cmd;
    assign w_ctl.batt_state        = i_in.batt_state;
    assign w_ctl.force_idle        = i_in.force_idle;
    assign w_ctl.chipset_off       = i_in.chipset_off;
    assign w_ctl.target_is_battery = i_in.target_is_battery;
    assign w_ctl.red_req           = (i_in.red_level != '0);
    assign w_ctl.green_req         = (i_in.green_level != '0);

    bli_div #(
        .CAP_WIDTH (CAP_WIDTH),
        .QW        (QW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (i_in.full_capacity),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_pm = r_use_div ? w_quot : '0;

    // The blink counter advances on every tick before the LED rules see it.
    assign w_blink = (r_ctl.cmd == CMD_TICK) ? r_blink + 2'd1 : r_blink;

    bli_policy #(
        .PM_WIDTH (QW)
    ) u_policy (
        .i_ctl   (r_ctl),
        .i_cfg   (r_cfg),
        .i_blink (w_blink),
        .i_pm    (w_pm),
        .i_red   (r_red),
        .i_green (r_green),
        .o_res   (w_res)
    );

    // Commit the result once the output register is free or draining.
    assign w_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_need_div ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Item and LED state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink     <= 2'd0;
            r_red       <= 1'b0;
            r_green     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_blink     <= w_blink;
                r_red       <= w_res.red;
                r_green     <= w_res.green;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_in_acc) begin
            r_ctl     <= w_ctl;
            r_use_div <= w_need_div;
        end
        if (w_load) begin
            r_out <= w_res;
        end
    end

    // Configuration writes; an index past the list is dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_control      <= 1'b1;
            r_cfg.critical_permille <= RST_CRITICAL;
            r_cfg.low_permille      <= RST_LOW;
            r_cfg.full_permille     <= RST_FULL;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_AUTO_CONTROL: r_cfg.auto_control      <= i_cfg.data[0];
                REG_CRITICAL:     r_cfg.critical_permille <= i_cfg.data;
                REG_LOW:          r_cfg.low_permille      <= i_cfg.data;
                REG_FULL:         r_cfg.full_permille     <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.red_on   = r_out.red;
    assign o_out.green_on = r_out.green;
    assign o_out.status   = r_out.status;

    a_div_busy_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_state == ST_DIV))
        else $error("divider busy outside the divide state");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_start_enters_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == ST_DIV) && w_div_busy)
        else $error("divide start did not enter the divide state");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && r_out_valid && !o_out.ready |=> (r_state == ST_DONE))
        else $error("result committed over an unread output");

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bli_pkg::*;

    localparam int CAP_W       = 16;
    // Worst-case divider pass of the block, plus handshake overhead.
    localparam int ITEM_CYCLES = CAP_W + 13;
    localparam int unsigned CYCLE_LIMIT = 600_000;

    // Charge states the block must treat as "hold the LEDs".
    localparam logic [2:0] CS_OTHER = 3'd5;
    localparam logic [2:0] CS_UNDEF = 3'd7;

    // Register index outside the register map; a write there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;

    typedef struct packed {
        logic               cmd;
        logic [2:0]         batt_state;
        logic               force_idle;
        logic               chipset_off;
        logic [CAP_W-1:0]   remaining;
        logic [CAP_W-1:0]   full;
        logic               target_is_battery;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
    } led_item_t;

    logic i_clk;
    logic i_rst_n;

    bli_in_if #(.CAP_WIDTH(CAP_W)) in_bus ();
    bli_out_if                     out_bus ();
    bli_cfg_if                     cfg_bus ();

    battery_led_indicator_policy #(
        .CAP_WIDTH(CAP_W)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus),
        .i_cfg  (cfg_bus)
    );

    // 20 ns clock.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // LED policy mirror: registers, blink counter and LED levels as the
    // block should hold them after every accepted transaction.
    // ------------------------------------------------------------------
    t_cfg        policy_cfg = '{1'b1, RST_CRITICAL, RST_LOW, RST_FULL};
    logic [1:0]  blink_phase = 2'd0;
    logic        red_lit = 1'b0;
    logic        green_lit = 1'b0;

    t_res        expected_leds[$];
    int unsigned items_sent;
    int unsigned results_matched;
    int unsigned ticks_seen;
    int unsigned manual_seen;
    int unsigned reg_writes;
    int unsigned mismatches;
    int unsigned cycle_cnt;

    bit          idle_on;
    int unsigned stall_left;

    // Advance the mirror by one transaction and return the LED result.
    function automatic t_res led_policy_predict(led_item_t it);
        logic [CAP_W+9:0] permille;
        t_res             res;
        res.status = STATUS_OK;
        if (it.cmd == CMD_TICK) begin
            blink_phase = blink_phase + 2'd1;
            if (policy_cfg.auto_control) begin
                // Unknown full capacity reads as empty; remaining above
                // full gives a permille beyond 1000, compared as is.
                permille = (it.full == '0) ? '0 : (PERMILLE_SCALE * it.remaining) / it.full;
                case (it.batt_state)
                    CS_CHARGE: begin
                        red_lit   = (permille >= policy_cfg.full_permille);
                        green_lit = (permille < policy_cfg.full_permille);
                    end
                    CS_NEAR_FULL: begin
                        red_lit   = 1'b1;
                        green_lit = 1'b0;
                    end
                    CS_DISCHARGE: begin
                        red_lit = 1'b0;
                        if (!it.chipset_off && permille <= policy_cfg.critical_permille) begin
                            green_lit = ~blink_phase[0];
                        end else if (!it.chipset_off && permille <= policy_cfg.low_permille) begin
                            green_lit = (blink_phase == 2'd0);
                        end else begin
                            green_lit = 1'b0;
                        end
                    end
                    CS_ERROR: begin
                        red_lit   = 1'b0;
                        green_lit = ~blink_phase[0];
                    end
                    CS_IDLE: begin
                        red_lit   = it.force_idle ? ~blink_phase[1] : 1'b1;
                        green_lit = it.force_idle ? blink_phase[1] : 1'b0;
                    end
                    default: begin
                        // Other and undefined states hold the LEDs.
                    end
                endcase
            end
        end else if (it.target_is_battery) begin
            // Red wins when both levels are requested.
            red_lit   = (it.red_level != '0);
            green_lit = (it.red_level == '0) && (it.green_level != '0);
        end else begin
            res.status = STATUS_BAD_TARGET;
        end
        res.red   = red_lit;
        res.green = green_lit;
        return res;
    endfunction

    function automatic void check_field(string name, logic want, logic seen);
        if (seen !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, seen);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: track register writes, predict on every accepted input
    // transaction, compare every accepted result with the oldest one.
    // Everything is sampled at the edge, so all values are pre-edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        led_item_t got;
        t_res      seen;
        t_res      want;
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                reg_writes++;
                case (cfg_bus.index)
                    REG_AUTO_CONTROL: policy_cfg.auto_control      = cfg_bus.data[0];
                    REG_CRITICAL:     policy_cfg.critical_permille = cfg_bus.data;
                    REG_LOW:          policy_cfg.low_permille      = cfg_bus.data;
                    REG_FULL:         policy_cfg.full_permille     = cfg_bus.data;
                    default: begin
                        // Unmapped index: drop the write.
                    end
                endcase
            end
            if (in_bus.valid && in_bus.ready) begin
                got = {in_bus.cmd, in_bus.batt_state, in_bus.force_idle,
                       in_bus.chipset_off, in_bus.remain_cap, in_bus.full_capacity,
                       in_bus.target_is_battery, in_bus.red_level, in_bus.green_level};
                if (got.cmd == CMD_TICK) ticks_seen++;
                else manual_seen++;
                expected_leds.push_back(led_policy_predict(got));
            end
            if (out_bus.valid && out_bus.ready) begin
                seen = {out_bus.red_on, out_bus.green_on, out_bus.status};
                if (expected_leds.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none actual red %0b green %0b status %0b",
                             $time, seen.red, seen.green, seen.status);
                end else begin
                    want = expected_leds.pop_front();
                    check_field("red_on", want.red, seen.red);
                    check_field("green_on", want.green, seen.green);
                    check_field("status", want.status, seen.status);
                    results_matched++;
                end
            end
        end
    end

    // Result side back-pressure: random stall bursts of random length.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            out_bus.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (idle_on && i_rst_n && $urandom_range(0, 7) == 0) begin
            out_bus.ready <= 1'b0;
            stall_left    <= $urandom_range(0, 15);
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    // Watchdog: a hung handshake ends the run here.
    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_cnt, expected_leds.size());
        $display("battery_led_indicator_policy verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers. Every task starts and ends on a rising edge.
    // ------------------------------------------------------------------

    // Offer one transaction, optionally after an idle burst, and hold it
    // until the block takes it. Valid stays high for back-to-back items.
    task automatic send_item(led_item_t it);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        {in_bus.cmd, in_bus.batt_state, in_bus.force_idle, in_bus.chipset_off,
         in_bus.remain_cap, in_bus.full_capacity, in_bus.target_is_battery,
         in_bus.red_level, in_bus.green_level} <= it;
        do @(posedge i_clk); while (!in_bus.ready);
        items_sent++;
    endtask

    // Drop valid and hold off until every expected result has come back.
    task automatic wait_quiet();
        in_bus.valid <= 1'b0;
        while (results_matched < items_sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERMILLE_W-1:0] data);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic led_item_t tick_item(logic [2:0] state, logic force_idle,
                                            logic chip_off, int unsigned rem,
                                            int unsigned full);
        led_item_t it;
        it                   = '0;
        it.cmd               = CMD_TICK;
        it.batt_state        = state;
        it.force_idle        = force_idle;
        it.chipset_off       = chip_off;
        it.remaining         = CAP_W'(rem);
        it.full              = CAP_W'(full);
        it.target_is_battery = 1'b1;
        return it;
    endfunction

    function automatic led_item_t manual_item(logic to_battery, logic [LEVEL_W-1:0] red,
                                              logic [LEVEL_W-1:0] green);
        led_item_t it;
        it                   = '0;
        it.cmd               = CMD_MANUAL;
        it.target_is_battery = to_battery;
        it.red_level         = red;
        it.green_level       = green;
        // Tick-only fields carry noise; the manual path must ignore them.
        it.batt_state        = 3'($urandom_range(0, 7));
        it.remaining         = CAP_W'($urandom);
        it.full              = CAP_W'($urandom);
        return it;
    endfunction

    // Mostly ticks; capacities mostly aimed so the permille lands around
    // the thresholds, with unknown and overfull capacities mixed in.
    function automatic led_item_t random_item();
        led_item_t       it;
        int unsigned     pick;
        longint unsigned rem;
        it.cmd               = ($urandom_range(0, 3) == 0) ? CMD_MANUAL : CMD_TICK;
        it.batt_state        = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                           : 3'($urandom_range(0, 4));
        it.force_idle        = 1'($urandom_range(0, 1));
        it.chipset_off       = ($urandom_range(0, 3) == 0);
        it.target_is_battery = ($urandom_range(0, 7) != 0);
        it.red_level         = ($urandom_range(0, 2) == 0) ? '0 : LEVEL_W'($urandom);
        it.green_level       = ($urandom_range(0, 2) == 0) ? '0 : LEVEL_W'($urandom);
        it.full              = CAP_W'($urandom);
        it.remaining         = CAP_W'($urandom);
        pick                 = $urandom_range(0, 9);
        if (pick == 0) begin
            it.full = '0;
        end else if (pick < 8) begin
            if (pick < 3) it.full = CAP_W'($urandom_range(1, 2000));
            if (it.full == '0) it.full = CAP_W'(1);
            rem = (longint'(it.full) * $urandom_range(0, 1100)) / 1000;
            it.remaining = (rem > {CAP_W{1'b1}}) ? {CAP_W{1'b1}} : CAP_W'(rem);
        end
        return it;
    endfunction

    // Quiesce, load all four registers, then push a batch of random items.
    task automatic run_setting(logic auto_on, int unsigned crit, int unsigned low,
                               int unsigned full, int unsigned n_items);
        wait_quiet();
        write_reg(REG_AUTO_CONTROL, PERMILLE_W'(auto_on));
        write_reg(REG_CRITICAL, PERMILLE_W'(crit));
        write_reg(REG_LOW, PERMILLE_W'(low));
        write_reg(REG_FULL, PERMILLE_W'(full));
        repeat (n_items) send_item(random_item());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: every command, every charge state, field extremes,
    // threshold edges, blink phases and the hold cases.
    task automatic test_directed();
        send_item(manual_item(1'b1, 8'hFF, 8'h00));
        send_item(manual_item(1'b1, 8'h00, 8'hFF));
        send_item(manual_item(1'b1, 8'h00, 8'h00));
        send_item(manual_item(1'b1, 8'h01, 8'h01));
        send_item(manual_item(1'b0, 8'hAA, 8'h55));
        send_item(tick_item(CS_CHARGE, 1'b0, 1'b0, 12345, 0));
        send_item(tick_item(CS_CHARGE, 1'b1, 1'b1, 65535, 65535));
        send_item(tick_item(CS_CHARGE, 1'b0, 1'b0, 936, 1000));
        send_item(tick_item(CS_CHARGE, 1'b0, 1'b0, 937, 1000));
        send_item(tick_item(CS_NEAR_FULL, 1'b0, 1'b0, 0, 0));
        repeat (2) send_item(tick_item(CS_DISCHARGE, 1'b0, 1'b0, 71, 1000));
        repeat (4) send_item(tick_item(CS_DISCHARGE, 1'b0, 1'b0, 137, 1000));
        send_item(tick_item(CS_DISCHARGE, 1'b0, 1'b1, 0, 1000));
        send_item(tick_item(CS_DISCHARGE, 1'b0, 1'b0, 65535, 1));
        repeat (2) send_item(tick_item(CS_ERROR, 1'b0, 1'b0, 500, 1000));
        repeat (2) send_item(tick_item(CS_IDLE, 1'b1, 1'b0, 500, 1000));
        send_item(tick_item(CS_IDLE, 1'b0, 1'b0, 500, 1000));
        send_item(tick_item(CS_OTHER, 1'b1, 1'b1, 65535, 0));
        send_item(tick_item(CS_UNDEF, 1'b0, 1'b0, 0, 65535));
    endtask

    // Auto control off: ticks only advance the blink counter, manual sets
    // still land. Only bit 0 of the write data counts.
    task automatic test_auto_off();
        wait_quiet();
        write_reg(REG_AUTO_CONTROL, 10'h3FE);
        send_item(manual_item(1'b1, 8'h00, 8'h80));
        send_item(tick_item(CS_CHARGE, 1'b0, 1'b0, 65535, 65535));
        send_item(tick_item(CS_NEAR_FULL, 1'b0, 1'b0, 0, 0));
        send_item(tick_item(CS_IDLE, 1'b1, 1'b0, 0, 0));
        send_item(manual_item(1'b1, 8'h80, 8'h00));
        send_item(tick_item(CS_ERROR, 1'b0, 1'b0, 0, 0));
        repeat (20) send_item(random_item());
        wait_quiet();
        write_reg(REG_AUTO_CONTROL, 10'h001);
    endtask

    // Threshold sweep through the extremes, including inverted orderings
    // and values past 1000, plus dropped writes to an unmapped index.
    task automatic test_thresholds();
        idle_on = 1'b1;
        run_setting(1'b1, 0, 0, 0, 40);
        run_setting(1'b1, 1023, 1023, 1023, 40);
        run_setting(1'b1, 1000, 0, 1000, 40);
        run_setting(1'b1, 0, 1000, 500, 40);
        wait_quiet();
        write_reg(REG_UNMAPPED, PERMILLE_W'($urandom));
        write_reg(REG_UNMAPPED, 10'h3FF);
        repeat (40) send_item(random_item());
    endtask

    // Random batches under random settings; each batch waits for the
    // pipeline to empty before reprogramming. The last batch runs with
    // no idling on either side.
    task automatic test_random();
        int unsigned crit;
        for (int batch = 0; batch < 10; batch++) begin
            idle_on = (batch < 9) && ($urandom_range(0, 3) != 0);
            crit    = $urandom_range(0, 1023);
            run_setting(($urandom_range(0, 4) != 0), crit,
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(crit, 1023),
                        $urandom_range(0, 1023), 105);
        end
        idle_on = 1'b0;
    endtask

    initial begin
        i_rst_n                   = 1'b0;
        in_bus.valid              = 1'b0;
        in_bus.cmd                = CMD_TICK;
        in_bus.batt_state         = CS_CHARGE;
        in_bus.force_idle         = 1'b0;
        in_bus.chipset_off        = 1'b0;
        in_bus.remain_cap         = '0;
        in_bus.full_capacity      = '0;
        in_bus.target_is_battery  = 1'b0;
        in_bus.red_level          = '0;
        in_bus.green_level        = '0;
        cfg_bus.valid             = 1'b0;
        cfg_bus.index             = REG_AUTO_CONTROL;
        cfg_bus.data              = '0;
        idle_on                   = 1'b1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_auto_off();
        test_thresholds();
        test_random();

        // Let the tail drain, then give the block a full item time to
        // reveal any stray result.
        wait_quiet();
        repeat (ITEM_CYCLES) @(posedge i_clk);
        if (expected_leds.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, expected_leds.size());
        end

        $display("Covered %0d transactions (%0d ticks, %0d manual sets), %0d results checked,",
                 items_sent, ticks_seen, manual_seen, results_matched);
        $display("%0d register writes across default, extreme and random thresholds; %0d mismatches",
                 reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("battery_led_indicator_policy verification clean");
        end else begin
            $display("battery_led_indicator_policy verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bli_pkg.sv
rtl/bli_if.sv
rtl/bli_div.sv
rtl/bli_policy.sv
rtl/battery_led_indicator_policy.sv
tb/sv/tb_top.sv
